// File: rtl/mswv_pkg.sv
package mswv_pkg;

  // item kinds
  typedef enum logic [2:0] {
    KIND_INIT    = 3'd0,
    KIND_REG     = 3'd1,
    KIND_CHECKIN = 3'd2,
    KIND_CRUMB   = 3'd3,
    KIND_TICK    = 3'd4,
    KIND_QUERY   = 3'd5
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_DONE
  } state_e;

  localparam logic [15:0] HW_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] SAT16          = 16'hFFFF;
  localparam logic [11:0] RELOAD_MAX     = 12'd4095;
  localparam int          CNT_SHIFT      = 5;   // 32 counts per ms
  localparam int          NUM_DIV        = 7;   // dividers 4 .. 256
  localparam int          CNT_W          = 16 + CNT_SHIFT;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  slot;
    logic [15:0] due_ms;
    logic [15:0] step_ms;
    logic [31:0] crumb_in;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  assigned_slot;
    logic        feed;
    logic        panic;
    logic [2:0]  stalled_slot;
    logic [15:0] elapsed_out;
    logic [31:0] crumb_out;
    logic [3:0]  slot_count;
    logic [2:0]  prescaler_code;
    logic [11:0] reload_value;
  } result_t;

  // one slot entry as stored in the table memory
  typedef struct packed {
    logic [15:0] deadline;
    logic [15:0] elapsed;
    logic [31:0] crumb;
  } entry_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [11:0] reload;
  } dog_t;

endpackage

// File: rtl/mswv_ram.sv
module mswv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mswv_dog.sv
module mswv_dog import mswv_pkg::*; (
  input  logic [15:0] ms_i,
  output dog_t        dog_o
);

  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] cnt;

  assign base = {ms_i, {CNT_SHIFT{1'b0}}};

  // smallest divider that fits wins, so scan from the largest down
  always_comb begin
    dog_o.code   = 3'(NUM_DIV - 1);
    dog_o.reload = RELOAD_MAX;
    cnt          = '0;
    for (int k = NUM_DIV - 1; k >= 0; k--) begin
      cnt = base >> (k + 2);
      if (cnt <= CNT_W'(RELOAD_MAX)) begin
        dog_o.code   = 3'(k);
        dog_o.reload = (cnt == '0) ? 12'd1 : cnt[11:0];
      end
    end
  end

endmodule

// File: rtl/mswv_seq.sv
module mswv_seq import mswv_pkg::*; #(
  parameter int MAX_SLOTS = 8,
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int CW = $clog2(MAX_SLOTS + 1),
  localparam int EW = $bits(entry_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  item_t         item_i,
  input  dog_t          dog_i,
  input  logic          out_free_i,
  output logic          res_valid_o,
  output result_t       res_o,
  output logic          mem_we_o,
  output logic [SW-1:0] mem_waddr_o,
  output logic [EW-1:0] mem_wdata_o,
  output logic          mem_re_o,
  output logic [SW-1:0] mem_raddr_o,
  input  logic [EW-1:0] mem_rdata_i
);

  state_e        state_q, state_d;
  item_t         item_q, item_d;
  result_t       res_q, res_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] idx_q, idx_d;
  logic          armed_q, armed_d;
  logic          panic_q, panic_d;

  entry_t          rd_entry, wr_entry;
  logic            slot_ok;
  logic [SW-1:0]   slot_idx;
  logic [16:0]     sum;
  logic [15:0]     nv;
  logic            last_slot;

  assign rd_entry  = entry_t'(mem_rdata_i);
  assign slot_ok   = {1'b0, item_q.slot} < 9'(count_q);
  assign slot_idx  = item_q.slot[SW-1:0];
  assign sum       = {1'b0, rd_entry.elapsed} + {1'b0, item_q.step_ms};
  assign nv        = sum[16] ? SAT16 : sum[15:0];
  assign last_slot = (CW'(idx_q) + CW'(1)) == count_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign mem_wdata_o = EW'(wr_entry);

  always_comb begin
    res_o            = res_q;
    res_o.slot_count = 4'(count_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC, ST_MOD: begin
        state_d = mem_re_o ? ST_MOD : ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    item_d      = item_q;
    res_d       = res_q;
    count_d     = count_q;
    idx_d       = idx_q;
    armed_d     = armed_q;
    panic_d     = panic_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    wr_entry    = rd_entry;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) item_d = item_i;
      end
      ST_EXEC: begin
        res_d = '0;
        case (item_q.kind)
          KIND_INIT: begin
            count_d              = '0;
            panic_d              = 1'b0;
            armed_d              = 1'b1;
            res_d.accepted       = 1'b1;
            res_d.prescaler_code = dog_i.code;
            res_d.reload_value   = dog_i.reload;
          end
          KIND_REG: begin
            if (!panic_q && count_q < CW'(MAX_SLOTS)) begin
              mem_we_o            = 1'b1;
              mem_waddr_o         = SW'(count_q);
              wr_entry            = '{deadline: item_q.due_ms,
                                      elapsed: 16'd0, crumb: 32'd0};
              res_d.accepted      = 1'b1;
              res_d.assigned_slot = 3'(count_q);
              count_d             = count_q + CW'(1);
            end
          end
          KIND_CHECKIN, KIND_CRUMB: begin
            if (!panic_q && slot_ok) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot_idx;
            end
          end
          KIND_QUERY: begin
            if (slot_ok) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot_idx;
            end
          end
          KIND_TICK: begin
            if (armed_q && !panic_q) begin
              res_d.accepted = 1'b1;
              idx_d          = '0;
              if (count_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
              end else begin
                res_d.feed = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_MOD: begin
        case (item_q.kind)
          KIND_CHECKIN: begin
            mem_we_o         = 1'b1;
            mem_waddr_o      = slot_idx;
            wr_entry.elapsed = 16'd0;
            res_d.accepted   = 1'b1;
          end
          KIND_CRUMB: begin
            mem_we_o       = 1'b1;
            mem_waddr_o    = slot_idx;
            wr_entry.crumb = item_q.crumb_in;
            res_d.accepted = 1'b1;
          end
          KIND_QUERY: begin
            res_d.accepted    = 1'b1;
            res_d.elapsed_out = rd_entry.elapsed;
            res_d.crumb_out   = rd_entry.crumb;
          end
          KIND_TICK: begin
            // write back this slot, read the next one in the same cycle
            mem_we_o         = 1'b1;
            mem_waddr_o      = idx_q;
            wr_entry.elapsed = nv;
            if (nv > rd_entry.deadline) begin
              panic_d            = 1'b1;
              res_d.panic        = 1'b1;
              res_d.stalled_slot = 3'(idx_q);
            end else if (last_slot) begin
              res_d.feed = 1'b1;
            end else begin
              idx_d       = idx_q + SW'(1);
              mem_re_o    = 1'b1;
              mem_raddr_o = idx_q + SW'(1);
            end
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        res_valid_o = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      armed_q <= 1'b0;
      panic_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      armed_q <= armed_d;
      panic_q <= panic_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

endmodule

// File: rtl/multi_slot_watchdog_voter.sv
// path from input accept to result word: init, register, tick on an empty table and
//   refused items go from decode to the result; checkin, breadcrumb and query add a
//   table read step; a tick that walks n slots handles one slot per cycle through the
//   table memory port pair; the result is registered once the output register is free
// one word at a time, the next accepted the cycle after the result is registered
// reset clears control state and the voter comes up unarmed; table contents are
//   only read after a register word has written them
module multi_slot_watchdog_voter import mswv_pkg::*; #(
  parameter int MAX_SLOTS = 8,
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int EW = $bits(entry_t)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  slot_i,
  input  logic [15:0] due_ms_i,
  input  logic [15:0] step_ms_i,
  input  logic [31:0] crumb_in_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [2:0]  assigned_slot_o,
  output logic        feed_o,
  output logic        panic_o,
  output logic [2:0]  stalled_slot_o,
  output logic [15:0] elapsed_out_o,
  output logic [31:0] crumb_out_o,
  output logic [3:0]  slot_count_o,
  output logic [2:0]  prescaler_code_o,
  output logic [11:0] reload_value_o
);

  // hardware dog timeout, to be written by the user only while the voter is idle; not enforced here
  logic [15:0] hw_timeout_q;

  // output register, lets the sequencer finish while a result waits
  logic    out_valid_q;
  result_t out_q;
  logic    out_free;

  item_t   item;
  dog_t    dog;
  result_t res;
  logic    res_valid;

  // table memory port signals
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [SW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  assign item = '{kind: kind_i, slot: slot_i, due_ms: due_ms_i,
                  step_ms: step_ms_i, crumb_in: crumb_in_i};

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_timeout_q <= HW_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      hw_timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  // prescaler and reload from the configured timeout, used by init
  mswv_dog u_dog (
    .ms_i  (hw_timeout_q),
    .dog_o (dog)
  );

  // item sequencer: decode, read-modify-write of the slot table, tick walk
  mswv_seq #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .dog_i       (dog),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // one entry per slot: deadline, elapsed count, breadcrumb
  mswv_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_q.accepted;
  assign assigned_slot_o  = out_q.assigned_slot;
  assign feed_o           = out_q.feed;
  assign panic_o          = out_q.panic;
  assign stalled_slot_o   = out_q.stalled_slot;
  assign elapsed_out_o    = out_q.elapsed_out;
  assign crumb_out_o      = out_q.crumb_out;
  assign slot_count_o     = out_q.slot_count;
  assign prescaler_code_o = out_q.prescaler_code;
  assign reload_value_o   = out_q.reload_value;

endmodule

// File: rtl/mswv_chk.sv
module mswv_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        accepted_o,
  input logic [2:0]  assigned_slot_o,
  input logic        feed_o,
  input logic        panic_o,
  input logic [2:0]  stalled_slot_o,
  input logic [15:0] elapsed_out_o,
  input logic [31:0] crumb_out_o,
  input logic [3:0]  slot_count_o,
  input logic [2:0]  prescaler_code_o,
  input logic [11:0] reload_value_o
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(accepted_o) &&
      $stable(assigned_slot_o) && $stable(feed_o) && $stable(panic_o) &&
      $stable(stalled_slot_o) && $stable(slot_count_o) && $stable(crumb_out_o) &&
      $stable(elapsed_out_o) && $stable(prescaler_code_o) && $stable(reload_value_o))
    else $error("result word changed while stalled");

  // a tick either feeds or panics, never both, and both need acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (feed_o || panic_o) |-> accepted_o && !(feed_o && panic_o))
    else $error("feed and panic inconsistent");

  // a refused word carries no init report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> reload_value_o == 12'd0 && prescaler_code_o == 3'd0)
    else $error("refused word with init report");

  // an init report with a nonzero prescaler code has a nonzero reload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prescaler_code_o != 3'd0 |-> reload_value_o != 12'd0)
    else $error("zero reload with prescaler code");

endmodule

bind multi_slot_watchdog_voter mswv_chk u_mswv_chk (.*);
